### rtl/core/ssp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the status packet receiver.
package ssp_pkg;

  localparam int BUFFER_BYTES = 32;

  localparam logic [7:0]  HDR_FF   = 8'hFF;
  localparam logic [7:0]  HDR_FD   = 8'hFD;
  localparam logic [7:0]  HDR_00   = 8'h00;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Result kinds.
  localparam logic [1:0] RK_BYTE    = 2'd0;
  localparam logic [1:0] RK_DONE    = 2'd1;
  localparam logic [1:0] RK_TIMEOUT = 2'd2;
  localparam logic [1:0] RK_LENGTH  = 2'd3;

  // Input kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] value;
    logic [4:0] index;
    logic [5:0] count;
    logic       crc_ok;
  } ssp_result_t;

  // CRC-16, MSB first, no reflection: one byte folded in over eight bit steps.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/ssp_frame_fsm.sv
// Packet framing state machine: header hunt, length check, byte indexing and CRC.
module ssp_frame_fsm
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output ssp_result_t res
);

  localparam logic [3:0] PH_HDR0  = 4'd0;
  localparam logic [3:0] PH_HDR1  = 4'd1;
  localparam logic [3:0] PH_HDR2  = 4'd2;
  localparam logic [3:0] PH_HDR3  = 4'd3;
  localparam logic [3:0] PH_ID    = 4'd4;
  localparam logic [3:0] PH_LENLO = 4'd5;
  localparam logic [3:0] PH_LENHI = 4'd6;
  localparam logic [3:0] PH_INSTR = 4'd7;
  localparam logic [3:0] PH_PARAM = 4'd8;
  localparam logic [3:0] PH_CRCLO = 4'd9;
  localparam logic [3:0] PH_CRCHI = 4'd10;

  // Largest accepted length field: instruction plus two CRC bytes plus a full buffer less ID.
  localparam logic [15:0] LEN_MIN = 16'd3;
  localparam logic [15:0] LEN_MAX = 16'(BUFFER_BYTES + 2);

  logic [3:0]  phase_r, phase_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len;
  logic [7:0]  remain_dec;

  assign crc_upd    = crc_add(crc_r, data_byte);
  assign len        = {data_byte, remain_r};
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res        = '0;

    if (kind == KIND_TIMEOUT) begin
      phase_nxt  = PH_HDR0;
      count_nxt  = '0;
      remain_nxt = '0;
      crc_nxt    = '0;
      crc_lo_nxt = '0;
      res.valid  = 1'b1;
      res.kind   = RK_TIMEOUT;
    end else begin
      case (phase_r)
        PH_HDR0, PH_HDR1: begin
          if (data_byte == HDR_FF) begin
            crc_nxt   = crc_upd;
            phase_nxt = phase_r + 4'd1;
          end
        end
        PH_HDR2: begin
          if (data_byte == HDR_FD) begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_HDR3;
          end
        end
        PH_HDR3: begin
          if (data_byte == HDR_00) begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_ID;
          end
        end
        PH_ID: begin
          crc_nxt   = crc_upd;
          count_nxt = 6'd1;
          phase_nxt = PH_LENLO;
          res.valid = 1'b1;
          res.kind  = RK_BYTE;
          res.value = data_byte;
        end
        PH_LENLO: begin
          crc_nxt    = crc_upd;
          remain_nxt = data_byte;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          if (len < LEN_MIN || len > LEN_MAX) begin
            phase_nxt  = PH_HDR0;
            count_nxt  = '0;
            remain_nxt = '0;
            crc_nxt    = '0;
            crc_lo_nxt = '0;
            res.valid  = 1'b1;
            res.kind   = RK_LENGTH;
          end else begin
            crc_nxt    = crc_upd;
            remain_nxt = len[7:0] - LEN_MIN[7:0];
            phase_nxt  = PH_INSTR;
          end
        end
        PH_INSTR: begin
          crc_nxt   = crc_upd;
          phase_nxt = (remain_r == 8'd0) ? PH_CRCLO : PH_PARAM;
        end
        PH_PARAM: begin
          crc_nxt    = crc_upd;
          count_nxt  = count_r + 6'd1;
          remain_nxt = remain_dec;
          if (remain_dec == 8'd0) begin
            phase_nxt = PH_CRCLO;
          end
          res.valid = 1'b1;
          res.kind  = RK_BYTE;
          res.value = data_byte;
          res.index = count_r[4:0];
        end
        PH_CRCLO: begin
          crc_lo_nxt = data_byte;
          phase_nxt  = PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_nxt  = PH_HDR0;
          count_nxt  = '0;
          remain_nxt = '0;
          crc_nxt    = '0;
          crc_lo_nxt = '0;
          res.valid  = 1'b1;
          res.kind   = RK_DONE;
          res.count  = count_r;
          res.crc_ok = ({data_byte, crc_lo_r} == crc_r);
        end
        default: begin
          phase_nxt  = PH_HDR0;
          count_nxt  = '0;
          remain_nxt = '0;
          crc_nxt    = '0;
          crc_lo_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      count_r  <= '0;
      remain_r <= '0;
      crc_r    <= '0;
      crc_lo_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

### rtl/core/servo_status_packet_receiver_top.sv
// Top level of the servo status packet receiver: input register, framing logic, result register.
//
//  channel  direction  ports
//  in       input      in_valid, in_ready, in_kind, in_data_byte
//  out      output     out_valid, out_ready, out_result_kind, out_byte_value,
//                      out_byte_index, out_byte_count, out_crc_ok
//
// One transaction per clock is sustained while the result register is not stalled. An accepted
// input transaction is loaded into the input register; when it advances, the framing logic and
// CRC byte update load its result into the result register.
// Synchronous active-low reset returns the framer to the header hunt and empties both registers.
// A stalled result holds the pipeline; the input register still takes one transaction ahead.
module servo_status_packet_receiver_top
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte_value,
  output logic [4:0] out_byte_index,
  output logic [5:0] out_byte_count,
  output logic       out_crc_ok
);

  logic        in_v_r;
  logic        in_kind_r;
  logic [7:0]  in_byte_r;
  logic        advance;
  ssp_result_t res;
  ssp_result_t out_r;

  assign advance  = in_v_r && (!out_r.valid || out_ready);
  assign in_ready = !in_v_r || advance;

  ssp_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .kind      (in_kind_r),
    .data_byte (in_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_data_byte;
    end
  end

  // Only the valid bit needs reset; the payload is qualified by it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r.valid <= res.valid;
    end else if (out_ready) begin
      out_r.valid <= 1'b0;
    end
    if (advance) begin
      out_r.kind   <= res.kind;
      out_r.value  <= res.value;
      out_r.index  <= res.index;
      out_r.count  <= res.count;
      out_r.crc_ok <= res.crc_ok;
    end
  end

  assign out_valid       = out_r.valid;
  assign out_result_kind = out_r.kind;
  assign out_byte_value  = out_r.value;
  assign out_byte_index  = out_r.index;
  assign out_byte_count  = out_r.count;
  assign out_crc_ok      = out_r.crc_ok;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the servo status packet receiver: framed and broken packets.
module tb_top;
  import ssp_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [3:0] {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_ID, P_LEN_LO, P_LEN_HI,
    P_INSTR, P_PARAM, P_CRC_LO, P_CRC_HI
  } frame_phase_e;

  typedef enum int {PK_GOOD, PK_BAD_CRC, PK_BAD_LENGTH, PK_CUT} packet_flavor_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [4:0] index;
    logic [5:0] count;
    logic       crc_ok;
  } status_result_t;

  // Tracks the framer state and holds the results each accepted transaction should produce.
  class status_frame_model;
    frame_phase_e   ph;
    logic [5:0]     stored;
    logic [15:0]    remaining;
    logic [15:0]    crc;
    logic [7:0]     crc_lo;
    status_result_t awaited_results[$];
    int errors, n_results, n_done, n_crc_bad, n_timeout, n_length;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      ph = P_HDR0;
      stored = '0;
      remaining = '0;
      crc = '0;
      crc_lo = '0;
    endfunction

    function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void predict_transaction(logic kind, logic [7:0] b);
      status_result_t r;
      int unsigned len;
      r = '0;
      if (kind == KIND_TIMEOUT) begin
        clear_frame();
        r.kind = RK_TIMEOUT;
        awaited_results.push_back(r);
        return;
      end
      case (ph)
        P_HDR0, P_HDR1: begin
          if (b == HDR_FF) begin
            crc = crc16_step(crc, b);
            ph = (ph == P_HDR0) ? P_HDR1 : P_HDR2;
          end
        end
        P_HDR2: begin
          if (b == HDR_FD) begin
            crc = crc16_step(crc, b);
            ph = P_HDR3;
          end
        end
        P_HDR3: begin
          if (b == HDR_00) begin
            crc = crc16_step(crc, b);
            ph = P_ID;
          end
        end
        P_ID: begin
          crc = crc16_step(crc, b);
          stored = 6'd1;
          ph = P_LEN_LO;
          r.kind = RK_BYTE;
          r.value = b;
          awaited_results.push_back(r);
        end
        P_LEN_LO: begin
          crc = crc16_step(crc, b);
          remaining = {8'h00, b};
          ph = P_LEN_HI;
        end
        P_LEN_HI: begin
          len = 32'({b, remaining[7:0]});
          crc = crc16_step(crc, b);
          if (len < 3 || len - 3 > BUFFER_BYTES - 1) begin
            clear_frame();
            r.kind = RK_LENGTH;
            awaited_results.push_back(r);
          end else begin
            remaining = 16'(len - 3);
            ph = P_INSTR;
          end
        end
        P_INSTR: begin
          crc = crc16_step(crc, b);
          ph = (remaining == 0) ? P_CRC_LO : P_PARAM;
        end
        P_PARAM: begin
          r.kind = RK_BYTE;
          r.value = b;
          r.index = stored[4:0];
          crc = crc16_step(crc, b);
          stored = stored + 6'd1;
          remaining = remaining - 16'd1;
          if (remaining == 0) ph = P_CRC_LO;
          awaited_results.push_back(r);
        end
        P_CRC_LO: begin
          crc_lo = b;
          ph = P_CRC_HI;
        end
        P_CRC_HI: begin
          r.kind = RK_DONE;
          r.count = stored;
          r.crc_ok = ({b, crc_lo} == crc);
          clear_frame();
          awaited_results.push_back(r);
        end
        default: clear_frame();
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_transaction(logic [1:0] kind, logic [7:0] value, logic [4:0] index,
                                    logic [5:0] count, logic crc_ok);
      status_result_t want;
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result of kind %0d arrived with nothing outstanding", kind);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("result_kind", 8'(want.kind), 8'(kind));
      compare_field("byte_value", want.value, value);
      compare_field("byte_index", 8'(want.index), 8'(index));
      compare_field("byte_count", 8'(want.count), 8'(count));
      compare_field("crc_ok", 8'(want.crc_ok), 8'(crc_ok));
      case (want.kind)
        RK_DONE: begin
          n_done++;
          if (!want.crc_ok) n_crc_bad++;
        end
        RK_TIMEOUT: n_timeout++;
        RK_LENGTH: n_length++;
        default: ;
      endcase
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_kind;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_result_kind;
  logic [7:0] out_byte_value;
  logic [4:0] out_byte_index;
  logic [5:0] out_byte_count;
  logic       out_crc_ok;

  status_frame_model sb = new();
  int send_idle_pct = 25;
  int recv_idle_pct = 49;
  int items_sent = 0;
  int cycles = 0;

  servo_status_packet_receiver_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_byte_value(out_byte_value),
    .out_byte_index(out_byte_index),
    .out_byte_count(out_byte_count),
    .out_crc_ok(out_crc_ok)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_transaction(out_result_kind, out_byte_value, out_byte_index, out_byte_count,
                           out_crc_ok);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  // Valid is left high so back-to-back transactions need no second assignment in a step.
  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_transaction(kind, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input packet_flavor_e flavor);
    logic [7:0] body[$];
    logic [7:0] line_bytes[$];
    logic [7:0] nb;
    logic [15:0] c;
    int unsigned len;
    int n_par;
    int cut;
    int r;
    // A partial header left by noise would swallow the packet, so resync first.
    if (sb.ph != P_HDR0) send_item(KIND_TIMEOUT, 8'($urandom));
    body = '{HDR_FF, HDR_FF, HDR_FD, HDR_00};
    foreach (body[i]) begin
      if ($urandom_range(9) == 0) begin
        nb = 8'($urandom);
        if (nb == body[i]) nb = ~nb;
        line_bytes.push_back(nb);
      end
      line_bytes.push_back(body[i]);
    end
    r = $urandom_range(99);
    if (r < 10) n_par = BUFFER_BYTES - 1;
    else if (r < 25) n_par = $urandom_range(7, BUFFER_BYTES - 1);
    else n_par = $urandom_range(0, 6);
    len = n_par + 3;
    if (flavor == PK_BAD_LENGTH) begin
      case ($urandom_range(3))
        0: len = $urandom_range(0, 2);
        1: len = $urandom_range(BUFFER_BYTES + 3, 255);
        2: len = 32'({8'($urandom_range(1, 255)), 8'($urandom)});
        default: len = BUFFER_BYTES + 3;
      endcase
    end
    body.push_back(8'($urandom));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (flavor != PK_BAD_LENGTH) begin
      body.push_back(8'($urandom));
      repeat (n_par) body.push_back(8'($urandom));
    end
    for (int i = 4; i < body.size(); i++) line_bytes.push_back(body[i]);
    if (flavor != PK_BAD_LENGTH) begin
      c = '0;
      foreach (body[i]) c = sb.crc16_step(c, body[i]);
      if (flavor == PK_BAD_CRC) c = c ^ (16'd1 << $urandom_range(0, 15));
      line_bytes.push_back(c[7:0]);
      line_bytes.push_back(c[15:8]);
    end
    cut = line_bytes.size();
    if (flavor == PK_CUT) cut = $urandom_range(1, line_bytes.size() - 1);
    for (int i = 0; i < cut; i++) send_item(KIND_BYTE, line_bytes[i]);
    if (flavor == PK_CUT) send_item(KIND_TIMEOUT, 8'($urandom));
  endtask

  initial begin
    logic [7:0] body[$];
    logic [7:0] seq[$];
    logic [15:0] c;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_data_byte = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Timeout while still hunting for the header.
    send_item(KIND_TIMEOUT, 8'hFF);
    // Length 3 packet with stray bytes at each header stage; ID at its largest value.
    body = '{HDR_FF, HDR_FF, HDR_FD, HDR_00, 8'hFF, 8'h03, 8'h00, 8'h55};
    c = '0;
    foreach (body[i]) c = sb.crc16_step(c, body[i]);
    seq = '{8'h00, HDR_FF, 8'h7E, HDR_FF, HDR_FF, HDR_FD, 8'h80, HDR_00,
            8'hFF, 8'h03, 8'h00, 8'h55, c[7:0], c[15:8]};
    foreach (seq[i]) send_item(KIND_BYTE, seq[i]);
    // Length below the instruction-plus-CRC minimum.
    seq = '{HDR_FF, HDR_FF, HDR_FD, HDR_00, 8'h00, 8'h02, 8'h00};
    foreach (seq[i]) send_item(KIND_BYTE, seq[i]);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 25;
      end
      r = $urandom_range(99);
      if (r < 8) repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
      else if (r < 12) send_item(KIND_TIMEOUT, 8'($urandom));
      else if (r < 70) send_packet(PK_GOOD);
      else if (r < 80) send_packet(PK_BAD_CRC);
      else if (r < 90) send_packet(PK_BAD_LENGTH);
      else send_packet(PK_CUT);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions under three sender/receiver stall mixes; checked %0d results.",
             items_sent, sb.n_results);
    $display("Packets done: %0d (%0d with CRC mismatch), timeout errors: %0d, length errors: %0d.",
             sb.n_done, sb.n_crc_bad, sb.n_timeout, sb.n_length);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
